[hdl/a85_pkg.sv]
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types, result codes and constants of the base-85 stream decoder.
// ----------------------------------------------------------------------------
package a85_pkg;

	// Result status codes as they appear on the output channel.
	localparam logic [2:0] StData  = 3'd0;
	localparam logic [2:0] StOvf   = 3'd1;
	localparam logic [2:0] StBad   = 3'd2;
	localparam logic [2:0] StLone  = 3'd3;
	localparam logic [2:0] StEnd   = 3'd4;

	// Characters with a meaning of their own.
	localparam logic [7:0] ChDigitLo = 8'h21;  // '!'
	localparam logic [7:0] ChDigitHi = 8'h75;  // 'u'
	localparam logic [7:0] ChZero    = 8'h7A;  // 'z'
	localparam logic [7:0] ChEnd     = 8'h7E;  // '~'

	// A stored partial group holds at most four digits, so it stays below 85^4.
	localparam int SumW      = 26;
	localparam int GroupW    = 33;
	localparam int PadMulW   = 20;
	localparam int ResIdxW   = 2;  // up to four results per character

	// Default depth of the command queue between front and back.
	localparam int QueueDepth = 4;

	// One queued command: the results that a single character causes.
	typedef struct packed {
		logic [31:0] word;    // group value, most significant byte first
		logic        ovf;     // group value went beyond 32 bits
		logic [2:0]  nbytes;  // data bytes to emit from word, 0 to 4
		logic        bad;     // one bad-character result
		logic        lone;    // one lone-final-digit result
		logic        fin;     // one end-of-stream result
	} a85_cmd_t;

	// Multiplier that pads a group of n digits with 'u' digits: 85^(5-n).
	function automatic logic [PadMulW-1:0] pad_mult(input logic [2:0] n);
		logic [PadMulW-1:0] m;
		case (n)
			3'd2:    m = PadMulW'(614125);
			3'd3:    m = PadMulW'(7225);
			3'd4:    m = PadMulW'(85);
			default: m = PadMulW'(1);
		endcase
		return m;
	endfunction

endpackage

[hdl/a85_if.sv]
// ----------------------------------------------------------------------------
// a85_if
// Valid/ready channels of the decoder: encoded characters in, results out.
// ----------------------------------------------------------------------------
interface a85_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       stream_start;

	modport source (output valid, output char_in, output stream_start, input ready);
	modport sink   (input valid, input char_in, input stream_start, output ready);
endinterface

interface a85_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] status;
	logic       run_last;

	modport source (output valid, output byte_out, output status, output run_last,
		input ready);
	modport sink   (input valid, input byte_out, input status, input run_last,
		output ready);
endinterface

[hdl/a85_front.sv]
// ----------------------------------------------------------------------------
// a85_front
// Accepts characters, keeps the group state and queues one command for
// every character that causes results.
// ----------------------------------------------------------------------------
module a85_front (
	input  logic               clk,
	input  logic               arst_n,
	a85_in_if.sink             in_ch,
	input  logic               full,
	output logic               push,
	output a85_pkg::a85_cmd_t  cmd
);

	logic [a85_pkg::SumW-1:0]    sum_q;
	logic [2:0]                  cnt_q;
	logic                        done_q;

	logic [a85_pkg::SumW-1:0]    eff_sum;
	logic [2:0]                  eff_cnt;
	logic                        eff_done;
	logic [7:0]                  c;
	logic                        is_space;
	logic                        is_digit;
	logic [a85_pkg::GroupW-1:0]  digit_val;
	logic [a85_pkg::SumW:0]      sum_p1;
	logic [a85_pkg::GroupW-1:0]  pad_prod;
	logic [a85_pkg::GroupW-1:0]  pad_val;

	logic                        accept;
	logic [a85_pkg::SumW-1:0]    sum_d;
	logic [2:0]                  cnt_d;
	logic                        done_d;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && !full;
	assign c           = in_ch.char_in;

	// A stream start clears the group before the character is looked at.
	assign eff_sum  = in_ch.stream_start ? '0 : sum_q;
	assign eff_cnt  = in_ch.stream_start ? 3'd0 : cnt_q;
	assign eff_done = in_ch.stream_start ? 1'b0 : done_q;

	assign is_space = c inside {8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};
	assign is_digit = c inside {[a85_pkg::ChDigitLo:a85_pkg::ChDigitHi]};

	assign digit_val = {7'b0, eff_sum} * 33'd85
		+ {25'b0, c - a85_pkg::ChDigitLo};

	// Padding with 'u' digits: (sum + 1) * 85^(5-n) - 1, which stays below 2^33.
	assign sum_p1   = {1'b0, eff_sum} + 27'd1;
	assign pad_prod = {6'b0, sum_p1} * {13'b0, a85_pkg::pad_mult(eff_cnt)};
	assign pad_val  = pad_prod - 33'd1;

	always_comb begin
		push  = 1'b0;
		cmd   = '0;
		sum_d = eff_sum;
		cnt_d = eff_cnt;
		done_d = eff_done;
		if (eff_done || is_space) begin
			// nothing to do
		end else if (is_digit) begin
			if (eff_cnt == 3'd4) begin
				push       = 1'b1;
				cmd.word   = digit_val[31:0];
				cmd.ovf    = digit_val[32];
				cmd.nbytes = 3'd4;
				sum_d      = '0;
				cnt_d      = 3'd0;
			end else begin
				sum_d = digit_val[a85_pkg::SumW-1:0];
				cnt_d = eff_cnt + 3'd1;
			end
		end else if (c == a85_pkg::ChZero && eff_cnt == 3'd0) begin
			push       = 1'b1;
			cmd.nbytes = 3'd4;
		end else if (c == a85_pkg::ChEnd) begin
			push    = 1'b1;
			cmd.fin = 1'b1;
			if (eff_cnt == 3'd1) begin
				cmd.lone = 1'b1;
			end else if (eff_cnt >= 3'd2) begin
				cmd.word   = pad_val[31:0];
				cmd.ovf    = pad_val[32];
				cmd.nbytes = eff_cnt - 3'd1;
			end
			sum_d  = '0;
			cnt_d  = 3'd0;
			done_d = 1'b1;
		end else begin
			push    = 1'b1;
			cmd.bad = 1'b1;
		end
		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else if (accept) begin
			sum_q  <= sum_d;
			cnt_q  <= cnt_d;
			done_q <= done_d;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("digit count beyond four");

	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == 3'd0 && sum_q == '0))
		else $error("group not cleared after end of stream");

endmodule

[hdl/a85_queue.sv]
// ----------------------------------------------------------------------------
// a85_queue
// Short register queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
module a85_queue #(
	parameter int Depth = a85_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  a85_pkg::a85_cmd_t  wdata,
	output logic               full,
	input  logic               pop,
	output a85_pkg::a85_cmd_t  rdata,
	output logic               empty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	a85_pkg::a85_cmd_t mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full  = count_q == CntW'(Depth);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

[hdl/a85_back.sv]
// ----------------------------------------------------------------------------
// a85_back
// Expands each queued command into its results, one per cycle while the sink
// does not stall, through an output register.
// ----------------------------------------------------------------------------
module a85_back (
	input  logic               clk,
	input  logic               arst_n,
	input  a85_pkg::a85_cmd_t  head,
	input  logic               empty,
	output logic               pop,
	a85_out_if.source          out_ch
);

	logic                        out_valid_q;
	logic [7:0]                  byte_q;
	logic [2:0]                  status_q;
	logic                        last_q;
	logic [a85_pkg::ResIdxW-1:0] idx_q;

	logic        load;
	logic        head_valid;
	logic [2:0]  total;
	logic [2:0]  idx_w;
	logic        is_last;
	logic [2:0]  tail_pos;
	logic [7:0]  res_byte;
	logic [2:0]  res_status;

	assign head_valid = !empty;
	assign load       = !out_valid_q || out_ch.ready;
	assign total      = head.nbytes + {2'b0, head.bad} + {2'b0, head.lone}
		+ {2'b0, head.fin};
	assign idx_w      = {1'b0, idx_q};
	assign is_last    = idx_w == total - 3'd1;
	assign pop        = load && head_valid && is_last;
	assign tail_pos   = idx_w - head.nbytes;

	always_comb begin
		res_byte   = 8'd0;
		res_status = a85_pkg::StEnd;
		if (idx_w < head.nbytes) begin
			case (idx_q)
				2'd0:    res_byte = head.word[31:24];
				2'd1:    res_byte = head.word[23:16];
				2'd2:    res_byte = head.word[15:8];
				default: res_byte = head.word[7:0];
			endcase
			res_status = head.ovf ? a85_pkg::StOvf : a85_pkg::StData;
		end else if (head.bad) begin
			res_status = a85_pkg::StBad;
		end else if (head.lone && tail_pos == 3'd0) begin
			res_status = a85_pkg::StLone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? '0 : idx_q + a85_pkg::ResIdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			byte_q   <= res_byte;
			status_q <= res_status;
			last_q   <= is_last;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.byte_out = byte_q;
	assign out_ch.status   = status_q;
	assign out_ch.run_last = last_q;

	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_w < total))
		else $error("result index beyond the command's results");

endmodule

[hdl/ascii85_stream_decoder.sv]
// A result is registered in the command queue and then in the output register
// before it is offered on the output channel. Throughput: one character per cycle
// while the command queue has room; the output side delivers one result per cycle
// while the sink is ready, so bursts of four bytes drain through the queue.
// Reset clears the group state, empties the queue and drops the output valid; no
// clearing pass is needed and the first character is taken right after reset.
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Streaming base-85 decoder: one encoded character in per transfer, decoded
// bytes and status results out.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder #(
	parameter int QueueDepth = a85_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	a85_in_if.sink     in_ch,
	a85_out_if.source  out_ch
);

	// The front classifies every character in the cycle of its transfer and
	// updates the group accumulator, the digit count and the end flag at once.
	// Any character that produces results becomes a single command: up to four
	// data bytes of a group word, a bad-character marker, or an end-of-stream
	// marker after the padded tail bytes or a lone-digit marker. White space and
	// characters after the end marker leave no trace in the queue.
	a85_pkg::a85_cmd_t push_cmd;
	a85_pkg::a85_cmd_t head_cmd;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;

	a85_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// The queue lets the front keep taking characters while the back is still
	// working through an earlier group or waiting on a stalled output.
	a85_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (full),
		.pop    (pop),
		.rdata  (head_cmd),
		.empty  (empty)
	);

	// The back walks the head command one result per transfer, marking the
	// final one of each character, and releases the entry with that final
	// result. Its output register holds a result steady while the sink stalls.
	a85_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_cmd),
		.empty  (empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

[tb/a85_tb_pkg.sv]
// ----------------------------------------------------------------------------
// a85_tb_pkg
// Scoreboard of the base-85 stream decoder bench: a bit-exact decoder model
// fed with every input transfer, and an in-order check of every result.
// ----------------------------------------------------------------------------
package a85_tb_pkg;

	// White space characters that the decoder skips.
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChFf    = 8'h0C;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;

	localparam logic [63:0] Max32 = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] byte_val;
		logic [2:0] status;
		logic       run_last;
	} a85_result_t;

	class a85_scoreboard;
		logic [32:0]  group_sum;
		logic [2:0]   digit_count;
		logic         stream_done;
		a85_result_t  expected_q[$];
		logic [7:0]   step_byte[4];
		logic [2:0]   step_status[4];
		int           step_cnt;
		int           errors;

		function new();
			group_sum   = '0;
			digit_count = '0;
			stream_done = 1'b0;
			step_cnt    = 0;
			errors      = 0;
		endfunction

		function bit is_space(logic [7:0] c);
			return c inside {ChNul, ChTab, ChLf, ChFf, ChCr, ChSpace};
		endfunction

		function void add_result(logic [7:0] b, logic [2:0] st);
			step_byte[step_cnt]   = b;
			step_status[step_cnt] = st;
			step_cnt++;
		endfunction

		// Top n bytes of a group value, most significant first.
		function void add_bytes(logic [63:0] value, int n);
			logic [2:0]  st;
			logic [31:0] word;
			st   = (value > Max32) ? a85_pkg::StOvf : a85_pkg::StData;
			word = value[31:0];
			for (int i = 0; i < n; i++)
				add_result(8'(word >> (24 - 8 * i)), st);
		endfunction

		// Works out the results of one accepted character.
		function void note_char(logic [7:0] c, logic start);
			logic [63:0] padded;
			a85_result_t res;
			step_cnt = 0;
			if (start) begin
				group_sum   = '0;
				digit_count = '0;
				stream_done = 1'b0;
			end
			if (stream_done || is_space(c))
				return;
			if (c inside {[a85_pkg::ChDigitLo:a85_pkg::ChDigitHi]}) begin
				group_sum   = group_sum * 33'd85 + 33'(c - a85_pkg::ChDigitLo);
				digit_count = digit_count + 3'd1;
				if (digit_count >= 3'd5) begin
					add_bytes({31'b0, group_sum}, 4);
					group_sum   = '0;
					digit_count = '0;
				end
			end else if (c == a85_pkg::ChZero && digit_count == 3'd0) begin
				add_bytes(64'd0, 4);
			end else if (c == a85_pkg::ChEnd) begin
				if (digit_count == 3'd1) begin
					add_result(8'd0, a85_pkg::StLone);
				end else if (digit_count >= 3'd2) begin
					padded = {31'b0, group_sum};
					for (int d = int'(digit_count); d < 5; d++)
						padded = padded * 64'd85 + 64'd84;
					add_bytes(padded, int'(digit_count) - 1);
				end
				add_result(8'd0, a85_pkg::StEnd);
				group_sum   = '0;
				digit_count = '0;
				stream_done = 1'b1;
			end else begin
				add_result(8'd0, a85_pkg::StBad);
			end
			for (int i = 0; i < step_cnt; i++) begin
				res.byte_val = step_byte[i];
				res.status   = step_status[i];
				res.run_last = (i == step_cnt - 1);
				expected_q.push_back(res);
			end
		endfunction

		function void check_result(logic [7:0] b, logic [2:0] st, logic last);
			a85_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("unexpected result: byte_out %0h, status %0d, run_last %0b",
					b, st, last);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (b !== exp_res.byte_val) begin
				$error("byte_out: expected %0h, actual %0h", exp_res.byte_val, b);
				errors++;
			end
			if (st !== exp_res.status) begin
				$error("status: expected %0d, actual %0d", exp_res.status, st);
				errors++;
			end
			if (last !== exp_res.run_last) begin
				$error("run_last: expected %0b, actual %0b", exp_res.run_last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

[tb/tb_ascii85_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ascii85_stream_decoder
// Self-checking bench of the base-85 stream decoder. Characters are sent in
// bursts, results are taken under a varying stall pattern, and every result
// is compared in order with the scoreboard's decoder model.
// ----------------------------------------------------------------------------
module tb_ascii85_stream_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	// Far above the slowest correct run: a few hundred characters, at most four
	// results each, every result behind the receiver's stalls.
	localparam int CycleLimit = 200000;
	// Cycles allowed after the last expected result for stray results to show.
	localparam int TailCycles = 16;
	// Length of the long receiver hold-off that fills the command queue.
	localparam int HoldCycles = 80;

	typedef struct packed {
		logic [7:0] ch;
		logic       start;
	} char_item_t;

	// Receiver behaviour, chosen afresh for each stretch of cycles.
	typedef enum int {
		RxAlways,
		RxAlternate,
		RxMostly,
		RxSeldom,
		RxThreeOfFour
	} rx_mode_t;

	logic clk;
	logic arst_n;

	a85_in_if  in_if();
	a85_out_if out_if();

	ascii85_stream_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	a85_tb_pkg::a85_scoreboard sb;
	char_item_t    char_q[$];
	logic          next_start;
	bit            long_hold;
	int            cycle_count;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog: a hung handshake must not leave the run spinning forever.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Both channels are sampled at the rising edge, before any of the bench's
	// nonblocking drives land. An input transfer is noted before an output one
	// is checked, although a result can never leave in the cycle of its cause.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				sb.note_char(in_if.char_in, in_if.stream_start);
			if (out_if.valid && out_if.ready)
				sb.check_result(out_if.byte_out, out_if.status, out_if.run_last);
		end
	end

	// Receiver. It keeps its own pattern of stalls, and on request holds ready
	// low for a long stretch while the sender carries on offering characters.
	initial begin : receiver
		rx_mode_t mode;
		int       stretch;
		int       tick;
		mode    = RxAlways;
		stretch = 0;
		tick    = 0;
		out_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_if.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				if (stretch == 0) begin
					mode    = rx_mode_t'($urandom_range(RxThreeOfFour, RxAlways));
					stretch = $urandom_range(16, 64);
				end
				stretch--;
				tick++;
				case (mode)
					RxAlways:      out_if.ready <= 1'b1;
					RxAlternate:   out_if.ready <= tick[0];
					RxMostly:      out_if.ready <= ($urandom_range(0, 3) != 0);
					RxSeldom:      out_if.ready <= ($urandom_range(0, 3) == 0);
					default:       out_if.ready <= (tick[1:0] != 2'd3);
				endcase
			end
		end
	end

	// Queues one character; the first character after a request opens a stream.
	task automatic put_char(input logic [7:0] c);
		char_item_t item;
		item.ch    = c;
		item.start = next_start;
		next_start = 1'b0;
		char_q.push_back(item);
	endtask

	function automatic logic [7:0] pick_space();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0:       c = a85_tb_pkg::ChNul;
			1:       c = a85_tb_pkg::ChTab;
			2:       c = a85_tb_pkg::ChLf;
			3:       c = a85_tb_pkg::ChFf;
			4:       c = a85_tb_pkg::ChCr;
			default: c = a85_tb_pkg::ChSpace;
		endcase
		return c;
	endfunction

	// A character that is neither a digit, white space, 'z' nor '~'.
	function automatic logic [7:0] pick_bad();
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0: c = 8'($urandom_range(8'h76, 8'h79));
			1: begin
				c = 8'($urandom_range(8'h7B, 8'hFF));
				if (c == a85_pkg::ChEnd)
					c = 8'h7D;
			end
			default: begin
				c = 8'($urandom_range(8'h01, 8'h1F));
				if (c inside {a85_tb_pkg::ChTab, a85_tb_pkg::ChLf, a85_tb_pkg::ChFf,
						a85_tb_pkg::ChCr})
					c = 8'h01;
			end
		endcase
		return c;
	endfunction

	// A well-formed stream with random content: full groups, the odd 'z' group,
	// sprinkled white space and bad characters, then a partial group and '~'.
	// Now and then the end marker is left off, so that the next stream start
	// cuts into an open group.
	task automatic gen_stream();
		int  n_groups;
		int  tail;
		bit  hot;
		next_start = 1'b1;
		n_groups   = $urandom_range(0, 5);
		for (int g = 0; g < n_groups; g++) begin
			if ($urandom_range(0, 9) == 0) begin
				put_char(a85_pkg::ChZero);
			end else begin
				// Groups built from high digits often go beyond 32 bits.
				hot = ($urandom_range(0, 3) == 0);
				for (int d = 0; d < 5; d++) begin
					if (hot)
						put_char(8'($urandom_range(8'h72, a85_pkg::ChDigitHi)));
					else
						put_char(8'($urandom_range(a85_pkg::ChDigitLo,
							a85_pkg::ChDigitHi)));
					if ($urandom_range(0, 11) == 0)
						put_char(pick_space());
					if ($urandom_range(0, 29) == 0)
						put_char(pick_bad());
				end
			end
		end
		tail = $urandom_range(0, 4);
		hot  = ($urandom_range(0, 2) == 0);
		for (int d = 0; d < tail; d++)
			put_char(hot ? 8'($urandom_range(8'h72, a85_pkg::ChDigitHi))
				: 8'($urandom_range(a85_pkg::ChDigitLo, a85_pkg::ChDigitHi)));
		if (tail > 0 && $urandom_range(0, 9) == 0)
			put_char(a85_pkg::ChZero);
		if ($urandom_range(0, 7) != 0) begin
			put_char(a85_pkg::ChEnd);
			// Characters after the end marker are swallowed.
			if ($urandom_range(0, 4) == 0)
				put_char(8'($urandom_range(0, 255)));
		end
	endtask

	// Raw noise over the whole character range, with the odd stream start.
	task automatic gen_noise();
		char_item_t item;
		int         n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			item.ch    = 8'($urandom_range(0, 255));
			item.start = ($urandom_range(0, 7) == 0);
			char_q.push_back(item);
		end
	endtask

	task automatic gen_random(input int target);
		int first;
		first = char_q.size();
		while (char_q.size() - first < target) begin
			if ($urandom_range(0, 4) == 0)
				gen_noise();
			else
				gen_stream();
		end
	endtask

	// Directed opening: extreme digits, overflow of a full and of a padded
	// group, 'z' at and inside a group, bad characters, white space, a lone
	// final digit, a character after the end and a short padded tail.
	task automatic gen_directed();
		next_start = 1'b1;
		repeat (5) put_char(a85_pkg::ChDigitHi);
		put_char(a85_pkg::ChZero);
		put_char(a85_pkg::ChDigitLo);
		put_char(a85_pkg::ChZero);
		put_char("v");
		put_char(8'hFF);
		put_char(a85_tb_pkg::ChTab);
		put_char(a85_pkg::ChEnd);
		put_char("a");
		next_start = 1'b1;
		repeat (4) put_char(a85_pkg::ChDigitHi);
		put_char(a85_pkg::ChEnd);
		next_start = 1'b1;
		put_char("9");
		put_char("j");
		put_char(a85_pkg::ChEnd);
		next_start = 1'b1;
		repeat (5) put_char(a85_pkg::ChDigitLo);
	endtask

	// Sends every queued character. With gaps allowed the sender works in
	// bursts of random length with idle cycles between them. A transfer takes
	// place at the edge where valid and ready are both high; valid stays up
	// from one character to the next within a burst.
	task automatic send_all(input bit gaps);
		char_item_t item;
		int         burst_left;
		burst_left = 0;
		while (char_q.size() != 0) begin
			item = char_q.pop_front();
			if (gaps && burst_left == 0) begin
				in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			in_if.valid        <= 1'b1;
			in_if.char_in      <= item.ch;
			in_if.stream_start <= item.start;
			do
				@(posedge clk);
			while (!in_if.ready);
			burst_left--;
		end
		in_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb          = new();
		cycle_count = 0;
		long_hold   = 1'b0;
		next_start  = 1'b0;
		arst_n             <= 1'b0;
		in_if.valid        <= 1'b0;
		in_if.char_in      <= '0;
		in_if.stream_start <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gen_directed();
		send_all(1'b0);
		// The sender waits here until every expected result has come out.
		wait_drained();

		gen_random(100);
		send_all(1'b1);

		// Long hold-off on the output side while characters keep coming
		// back to back: the queue fills and the input must stall.
		long_hold = 1'b1;
		gen_random(30);
		send_all(1'b0);
		wait_drained();

		gen_random(90);
		send_all(1'b1);

		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
hdl/a85_pkg.sv
hdl/a85_if.sv
hdl/a85_front.sv
hdl/a85_queue.sv
hdl/a85_back.sv
hdl/ascii85_stream_decoder.sv
tb/a85_tb_pkg.sv
tb/tb_ascii85_stream_decoder.sv
